// ===== rtl/core/dot_matrix_row_capture_macros.svh =====
// Assertion macros used by the dot-matrix row capture RTL (dmrc_core).
// Expects clk and rst_n to be visible in the including module.
`ifndef DOT_MATRIX_ROW_CAPTURE_MACROS_SVH
`define DOT_MATRIX_ROW_CAPTURE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DMRC_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dmrc: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define DMRC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dmrc: next-cycle check failed");

`endif

// ===== rtl/core/dmrc_pkg.sv =====
// Package for the dot-matrix row capture block: constants, opcodes and
// the structs passed between its stages. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dmrc_pkg;

    localparam int BYTE_W     = 8;
    localparam int OP_W       = 2;
    localparam int ROW_W      = 5;
    localparam int PIX_W      = 64;
    localparam int COL_W      = 4;
    localparam int ROW_BYTES  = 9;
    localparam int ROW_LIMIT  = 21;

    // control byte bits
    localparam int CTRL_COL_CLR_BIT = 1;
    localparam int CTRL_BUSY_BIT    = 3;

    // row select field of the ninth byte
    localparam int ROW_SEL_LO = 2;
    localparam int ROW_SEL_HI = 6;

    typedef enum logic [OP_W-1:0] {
        OP_CTRL_WR = 2'd0,
        OP_MUX_WR  = 2'd1,
        OP_MB_RD   = 2'd2,
        OP_MB_WR   = 2'd3
    } op_t;

    typedef struct packed {
        logic              valid;
        op_t               op;
        logic [BYTE_W-1:0] data;
    } dmrc_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        logic              mailbox_full;
        logic              irq_pulse;
        logic              ready_line;
        logic              row_valid;
        logic [ROW_W-1:0]  row_index;
        logic [PIX_W-1:0]  row_pixels;
        logic              last_pixel;
    } dmrc_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/dmrc_ifs.sv =====
// Valid/ready channel interfaces for bus accesses in and results out.
// Depends on dmrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface dmrc_in_if
    import dmrc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] data;

    modport source (output valid, output operation, output data, input ready);
    modport sink   (input valid, input operation, input data, output ready);
endinterface

interface dmrc_out_if
    import dmrc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_byte;
    logic              mailbox_full;
    logic              irq_pulse;
    logic              ready_line;
    logic              row_valid;
    logic [ROW_W-1:0]  row_index;
    logic [PIX_W-1:0]  row_pixels;
    logic              last_pixel;

    modport source (
        output valid, output read_byte, output mailbox_full, output irq_pulse,
        output ready_line, output row_valid, output row_index, output row_pixels,
        output last_pixel, input ready
    );
    modport sink (
        input valid, input read_byte, input mailbox_full, input irq_pulse,
        input ready_line, input row_valid, input row_index, input row_pixels,
        input last_pixel, output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/dmrc_in_stage.sv =====
// Input register: captures one bus access and holds it until the core
// consumes it. Depends on dmrc_pkg and dmrc_ifs.
`timescale 1ns / 1ps
`default_nettype none

module dmrc_in_stage
    import dmrc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    dmrc_in_if.sink     in_ch,
    input  wire logic   advance,
    output dmrc_item_t  item
);

    logic              valid_reg;
    logic              valid_next;
    op_t               op_reg;
    logic [BYTE_W-1:0] data_reg;
    logic              accept;

    // free slot, or the held transaction leaves this cycle
    assign in_ch.ready = !valid_reg || advance;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op_t'(in_ch.operation);
            data_reg <= in_ch.data;
        end
    end

    assign item.valid = valid_reg;
    assign item.op    = op_reg;
    assign item.data  = data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/dmrc_core.sv =====
// Board state and access decode: control byte, column counter, busy flag,
// row buffer and mailbox. Depends on dmrc_pkg and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none

`include "dot_matrix_row_capture_macros.svh"

module dmrc_core
    import dmrc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire dmrc_item_t item,
    input  wire logic       advance,
    output dmrc_result_t    res
);

    logic [BYTE_W-1:0] ctrl_reg, ctrl_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic              busy_reg, busy_next;
    logic [BYTE_W-1:0] mb_byte_reg, mb_byte_next;
    logic              mb_valid_reg, mb_valid_next;

    logic [BYTE_W-1:0] row_buf [ROW_BYTES];
    logic              buf_we;
    logic [BYTE_W-1:0] buf_wdata;

    logic              fire;
    logic [BYTE_W-1:0] changed;
    logic [ROW_W-1:0]  row_sel;
    logic              row_in_range;
    logic [PIX_W-1:0]  pixels;

    assign fire    = item.valid && advance;
    assign changed = ctrl_reg ^ item.data;
    assign row_sel = ~item.data[ROW_SEL_HI:ROW_SEL_LO];
    assign row_in_range = {1'b0, row_sel} < (ROW_W+1)'(ROW_LIMIT);

    // bit 63 is entry 0 bit 7, bit 0 is entry 7 bit 0
    always_comb
    begin
        for (int i = 0; i < PIX_W / BYTE_W; i++)
        begin
            pixels[PIX_W-1-BYTE_W*i -: BYTE_W] = row_buf[i];
        end
    end

    always_comb
    begin
        ctrl_next     = ctrl_reg;
        col_next      = col_reg;
        busy_next     = busy_reg;
        mb_byte_next  = mb_byte_reg;
        mb_valid_next = mb_valid_reg;
        buf_we        = 1'b0;
        buf_wdata     = item.data;
        res           = '0;

        if (fire)
        begin
            unique case (item.op)
                OP_CTRL_WR:
                begin
                    ctrl_next = item.data;
                    if (changed[CTRL_COL_CLR_BIT] && !item.data[CTRL_COL_CLR_BIT])
                    begin
                        col_next = '0;
                    end
                    if (changed[CTRL_BUSY_BIT])
                    begin
                        busy_next = !item.data[CTRL_BUSY_BIT];
                    end
                end
                OP_MUX_WR:
                begin
                    if (col_reg < COL_W'(ROW_BYTES))
                    begin
                        buf_we   = 1'b1;
                        col_next = col_reg + COL_W'(1);
                    end
                    if (col_reg == COL_W'(ROW_BYTES - 1))
                    begin
                        // ninth byte keeps only its top bit
                        buf_wdata = {item.data[BYTE_W-1], {(BYTE_W-1){1'b0}}};
                        if (row_in_range)
                        begin
                            res.row_valid  = 1'b1;
                            res.row_index  = row_sel;
                            res.row_pixels = pixels;
                            res.last_pixel = item.data[BYTE_W-1];
                        end
                    end
                end
                OP_MB_RD:
                begin
                    if (mb_valid_reg)
                    begin
                        res.read_byte = mb_byte_reg;
                        mb_valid_next = 1'b0;
                    end
                end
                OP_MB_WR:
                begin
                    mb_byte_next  = item.data;
                    mb_valid_next = 1'b1;
                    res.irq_pulse = 1'b1;
                end
            endcase
        end

        res.mailbox_full = mb_valid_next;
        res.ready_line   = !busy_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg     <= '0;
            col_reg      <= '0;
            busy_reg     <= 1'b0;
            mb_byte_reg  <= '0;
            mb_valid_reg <= 1'b0;
        end
        else
        begin
            ctrl_reg     <= ctrl_next;
            col_reg      <= col_next;
            busy_reg     <= busy_next;
            mb_byte_reg  <= mb_byte_next;
            mb_valid_reg <= mb_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            row_buf[col_reg] <= buf_wdata;
        end
    end

    `DMRC_ASSERT_IMPLIES(a_col_range, 1'b1, col_reg <= COL_W'(ROW_BYTES))
    `DMRC_ASSERT_IMPLIES(a_row_from_ninth, res.row_valid,
        fire && item.op == OP_MUX_WR && col_reg == COL_W'(ROW_BYTES - 1))
    `DMRC_ASSERT_NEXT(a_mb_read_empties, fire && item.op == OP_MB_RD, !mb_valid_reg)
    `DMRC_ASSERT_NEXT(a_mb_write_fills, fire && item.op == OP_MB_WR,
        mb_valid_reg && mb_byte_reg == $past(item.data))

endmodule

`default_nettype wire

// ===== rtl/core/dmrc_out_stage.sv =====
// Result register: holds one finished result until the sink takes it and
// tells the upstream stages when they may advance. Depends on dmrc_pkg and dmrc_ifs.
`timescale 1ns / 1ps
`default_nettype none

module dmrc_out_stage
    import dmrc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         item_valid,
    input  wire dmrc_result_t res,
    output logic              advance,
    dmrc_out_if.source        out_ch
);

    logic         valid_reg;
    dmrc_result_t res_reg;

    // register is empty or being drained this cycle
    assign advance = !valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && item_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_ch.valid        = valid_reg;
    assign out_ch.read_byte    = res_reg.read_byte;
    assign out_ch.mailbox_full = res_reg.mailbox_full;
    assign out_ch.irq_pulse    = res_reg.irq_pulse;
    assign out_ch.ready_line   = res_reg.ready_line;
    assign out_ch.row_valid    = res_reg.row_valid;
    assign out_ch.row_index    = res_reg.row_index;
    assign out_ch.row_pixels   = res_reg.row_pixels;
    assign out_ch.last_pixel   = res_reg.last_pixel;

endmodule

`default_nettype wire

// ===== rtl/core/dot_matrix_row_capture.sv =====
// Dot-matrix display board bus logic: row capture, busy line and mailbox.
// The result passes through the input register, then the result register, before
// it is offered on out_ch. Throughput: one transaction per cycle while out_ch is
// ready, limited by the single state-update pass in dmrc_core. Async active-low
// reset clears control byte, column count, busy flag and mailbox; row buffer is
// not reset.
`timescale 1ns / 1ps
`default_nettype none

module dot_matrix_row_capture
    import dmrc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    dmrc_in_if.sink    in_ch,
    dmrc_out_if.source out_ch
);

    dmrc_item_t   item;
    dmrc_result_t res;
    logic         advance;

    dmrc_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .advance (advance),
        .item    (item)
    );

    dmrc_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .advance (advance),
        .res     (res)
    );

    dmrc_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .res        (res),
        .advance    (advance),
        .out_ch     (out_ch)
    );

endmodule

`default_nettype wire

// ===== bench/dot_matrix_row_capture_test.sv =====
// Self-checking bench for dot_matrix_row_capture: a directed table, then random
// bus accesses; each result is compared against a local predictor or a hand-written expected response.
// Depends on dmrc_pkg, dmrc_in_if / dmrc_out_if and the block's RTL.
`timescale 1ns / 1ps

module dot_matrix_row_capture_test;
    import dmrc_pkg::*;

    localparam int RANDOM_ITEMS = 500;
    localparam int HOLD_CYCLES  = 80;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam int PRINT_LIMIT  = 40;
    localparam int PLAN_ROWS    = 26;

    // one bus access, optionally with a hand-written expected response
    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] data;
        logic              fixed;
        dmrc_result_t      want;
    } access_t;

    logic clk;
    logic rst_n;

    dmrc_in_if  bus_in ();
    dmrc_out_if bus_out ();

    dot_matrix_row_capture dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (bus_in),
        .out_ch (bus_out)
    );

    // predictor state
    logic [BYTE_W-1:0] ctrl_q;
    logic [COL_W-1:0]  col_q;
    logic              busy_q;
    logic [BYTE_W-1:0] row_buf [ROW_BYTES];
    logic [BYTE_W-1:0] mb_q;
    logic              mb_full;

    dmrc_result_t pending_responses [$];
    access_t      access_log [$];
    access_t      plan [PLAN_ROWS];

    int  mismatches;
    int  items_issued;
    int  spare_writes;
    int  n_ctrl, n_mux, n_rd, n_wr;
    int  rows_shown, rows_dropped, mail_hits;
    bit  calm;
    bit  hold_req;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic dmrc_result_t response_of(
        logic [7:0] rb, logic full, logic irq, logic rdy,
        logic rv, logic [4:0] idx, logic [63:0] pix, logic last);
        dmrc_result_t r;
        r.read_byte    = rb;
        r.mailbox_full = full;
        r.irq_pulse    = irq;
        r.ready_line   = rdy;
        r.row_valid    = rv;
        r.row_index    = idx;
        r.row_pixels   = pix;
        r.last_pixel   = last;
        return r;
    endfunction

    // Applies one bus access to the predictor state and returns the response.
    function automatic dmrc_result_t compute_bus_response(op_t op, logic [BYTE_W-1:0] d);
        dmrc_result_t      r;
        logic [BYTE_W-1:0] flips;
        logic [COL_W-1:0]  col_old;
        logic [ROW_W-1:0]  sel;
        logic [PIX_W-1:0]  pix;
        r = '0;
        case (op)
            OP_CTRL_WR:
            begin
                flips  = ctrl_q ^ d;
                ctrl_q = d;
                if (flips[CTRL_COL_CLR_BIT] && !d[CTRL_COL_CLR_BIT])
                    col_q = '0;
                if (flips[CTRL_BUSY_BIT])
                    busy_q = !d[CTRL_BUSY_BIT];
            end
            OP_MUX_WR:
            begin
                col_old = col_q;
                if (col_old < ROW_BYTES)
                begin
                    row_buf[col_old] = d;
                    col_q = col_old + 1'b1;
                end
                if (col_old == ROW_BYTES - 1)
                begin
                    sel = ~d[ROW_SEL_HI:ROW_SEL_LO];
                    row_buf[ROW_BYTES-1] = {d[BYTE_W-1], {(BYTE_W-1){1'b0}}};
                    if (sel < ROW_LIMIT)
                    begin
                        pix = '0;
                        for (int i = 0; i < ROW_BYTES - 1; i++)
                            pix = {pix[PIX_W-BYTE_W-1:0], row_buf[i]};
                        r.row_valid  = 1'b1;
                        r.row_index  = sel;
                        r.row_pixels = pix;
                        r.last_pixel = d[BYTE_W-1];
                    end
                end
            end
            OP_MB_RD:
            begin
                if (mb_full)
                    r.read_byte = mb_q;
                mb_full = 1'b0;
            end
            default:
            begin
                mb_q        = d;
                mb_full     = 1'b1;
                r.irq_pulse = 1'b1;
            end
        endcase
        r.mailbox_full = mb_full;
        r.ready_line   = !busy_q;
        return r;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("ERROR at %0t: %s got %h, want %h", $time, what, got, want);
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report(name, got, want);
    endtask

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 60)
            return 0;
        if (k < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Drives one access and returns once it has been accepted, plus any gap.
    task automatic issue(op_t op, logic [BYTE_W-1:0] d, logic fixed, dmrc_result_t want);
        access_t a;
        int      gap;
        a.op    = op;
        a.data  = d;
        a.fixed = fixed;
        a.want  = want;
        access_log.push_back(a);
        bus_in.valid     <= 1'b1;
        bus_in.operation <= op;
        bus_in.data      <= d;
        @(posedge clk);
        while (!bus_in.ready)
            @(posedge clk);
        items_issued++;
        gap = calm ? 0 : idle_len();
        if (gap > 0)
        begin
            bus_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic settle();
        bus_in.valid <= 1'b0;
        @(posedge clk);
        while (pending_responses.size() != 0)
            @(posedge clk);
    endtask

    // acceptance on both channels, in a fixed order within the cycle
    always @(posedge clk)
    begin
        access_t      a;
        dmrc_result_t guess;
        dmrc_result_t want;
        op_t          op;
        if (rst_n)
        begin
            if (bus_in.valid && bus_in.ready)
            begin
                op = op_t'(bus_in.operation);
                case (op)
                    OP_CTRL_WR: n_ctrl++;
                    OP_MUX_WR:  n_mux++;
                    OP_MB_RD:   n_rd++;
                    default:    n_wr++;
                endcase
                if (op == OP_MB_RD && mb_full)
                    mail_hits++;
                if (op == OP_MUX_WR && col_q == ROW_BYTES - 1)
                    rows_dropped++;
                guess = compute_bus_response(op, bus_in.data);
                if (guess.row_valid)
                begin
                    rows_shown++;
                    rows_dropped--;
                end
                a = access_log.pop_front();
                pending_responses.push_back(a.fixed ? a.want : guess);
            end
            if (bus_out.valid && bus_out.ready)
            begin
                if (pending_responses.size() == 0)
                    report("unexpected result", '0, '0);
                else
                begin
                    want = pending_responses.pop_front();
                    check_field("read_byte", bus_out.read_byte, want.read_byte);
                    check_field("mailbox_full", bus_out.mailbox_full, want.mailbox_full);
                    check_field("irq_pulse", bus_out.irq_pulse, want.irq_pulse);
                    check_field("ready_line", bus_out.ready_line, want.ready_line);
                    check_field("row_valid", bus_out.row_valid, want.row_valid);
                    check_field("row_index", bus_out.row_index, want.row_index);
                    check_field("row_pixels", bus_out.row_pixels, want.row_pixels);
                    check_field("last_pixel", bus_out.last_pixel, want.last_pixel);
                end
            end
        end
    end

    // watchdog: cycles with no transaction on either side
    always @(posedge clk)
    begin
        int quiet;
        if (rst_n)
        begin
            if ((bus_in.valid && bus_in.ready) || (bus_out.valid && bus_out.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // result side: random stalls, one long hold on request
    initial
    begin
        int stall;
        stall = 0;
        bus_out.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall = HOLD_CYCLES;
            end
            else if (stall == 0 && !calm)
                stall = idle_len();
            if (stall > 0)
            begin
                bus_out.ready <= 1'b0;
                stall--;
            end
            else
                bus_out.ready <= 1'b1;
        end
    end

    initial
    begin
        int                k;
        int                n;
        bit                mid_pause;
        op_t               op;
        logic [BYTE_W-1:0] d;
        logic [ROW_W-1:0]  row;

        rst_n            = 1'b0;
        bus_in.valid     = 1'b0;
        bus_in.operation = OP_CTRL_WR;
        bus_in.data      = '0;
        ctrl_q           = '0;
        col_q            = '0;
        busy_q           = 1'b0;
        mb_q             = '0;
        mb_full          = 1'b0;
        foreach (row_buf[i])
            row_buf[i] = '0;
        mismatches   = 0;
        items_issued = 0;
        spare_writes = 0;
        calm         = 1'b0;
        hold_req     = 1'b0;
        mid_pause    = 1'b0;

        plan = '{
            '{OP_MB_RD,   8'h00, 1'b1, response_of(8'h00, 0, 0, 1, 0, 0, 0, 0)},
            '{OP_MB_WR,   8'hFF, 1'b1, response_of(8'h00, 1, 1, 1, 0, 0, 0, 0)},
            // overwrite while still full
            '{OP_MB_WR,   8'h5A, 1'b1, response_of(8'h00, 1, 1, 1, 0, 0, 0, 0)},
            '{OP_MB_RD,   8'hFF, 1'b1, response_of(8'h5A, 0, 0, 1, 0, 0, 0, 0)},
            '{OP_CTRL_WR, 8'h08, 1'b1, response_of(8'h00, 0, 0, 1, 0, 0, 0, 0)},
            '{OP_CTRL_WR, 8'hF2, 1'b1, response_of(8'h00, 0, 0, 0, 0, 0, 0, 0)},
            '{OP_MUX_WR,  8'hFF, 1'b0, '0},
            '{OP_MUX_WR,  8'h00, 1'b0, '0},
            '{OP_MUX_WR,  8'h80, 1'b0, '0},
            '{OP_MUX_WR,  8'h01, 1'b0, '0},
            '{OP_MUX_WR,  8'h55, 1'b0, '0},
            '{OP_MUX_WR,  8'hAA, 1'b0, '0},
            '{OP_MUX_WR,  8'h0F, 1'b0, '0},
            '{OP_MUX_WR,  8'hF0, 1'b0, '0},
            // ninth byte decodes to row 31: nothing emitted
            '{OP_MUX_WR,  8'h83, 1'b1, response_of(8'h00, 0, 0, 0, 0, 0, 0, 0)},
            // buffer already full
            '{OP_MUX_WR,  8'hFF, 1'b0, '0},
            // bit 1 falls (column clear), bit 3 rises (not busy)
            '{OP_CTRL_WR, 8'hF8, 1'b1, response_of(8'h00, 0, 0, 1, 0, 0, 0, 0)},
            '{OP_MUX_WR,  8'h01, 1'b0, '0},
            '{OP_MUX_WR,  8'h02, 1'b0, '0},
            '{OP_MUX_WR,  8'h04, 1'b0, '0},
            '{OP_MUX_WR,  8'h08, 1'b0, '0},
            '{OP_MUX_WR,  8'h10, 1'b0, '0},
            '{OP_MUX_WR,  8'h20, 1'b0, '0},
            '{OP_MUX_WR,  8'h40, 1'b0, '0},
            '{OP_MUX_WR,  8'h80, 1'b0, '0},
            // last row below the limit
            '{OP_MUX_WR,  8'h2F, 1'b1,
              response_of(8'h00, 0, 0, 1, 1, 20, 64'h0102040810204080, 0)}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < PLAN_ROWS; i++)
            issue(plan[i].op, plan[i].data, plan[i].fixed, plan[i].want);

        // sender waits for every result, then the receiver holds off for a while
        settle();
        hold_req = 1'b1;

        while (items_issued - spare_writes < PLAN_ROWS + RANDOM_ITEMS)
        begin
            if (!mid_pause && items_issued > PLAN_ROWS + RANDOM_ITEMS / 2)
            begin
                mid_pause = 1'b1;
                settle();
            end
            calm = ($urandom_range(0, 9) == 0);
            k = $urandom_range(0, 99);
            if (k < 65)
            begin
                // well-formed row: clear the column, nine bytes, maybe extras
                d = 8'($urandom_range(0, 255));
                d[CTRL_COL_CLR_BIT] = 1'b1;
                issue(OP_CTRL_WR, d, 1'b0, '0);
                d = 8'($urandom_range(0, 255));
                d[CTRL_COL_CLR_BIT] = 1'b0;
                issue(OP_CTRL_WR, d, 1'b0, '0);
                for (int b = 0; b < ROW_BYTES; b++)
                begin
                    if ($urandom_range(0, 6) == 0)
                    begin
                        op = op_t'($urandom_range(0, 3));
                        if (op == OP_MUX_WR)
                            op = OP_MB_RD;
                        d = 8'($urandom_range(0, 255));
                        d[CTRL_COL_CLR_BIT] = 1'b0;
                        issue(op, d, 1'b0, '0);
                    end
                    d = 8'($urandom_range(0, 255));
                    if (b == ROW_BYTES - 1 && $urandom_range(0, 3) != 0)
                    begin
                        row = 5'($urandom_range(0, ROW_LIMIT - 1));
                        d[ROW_SEL_HI:ROW_SEL_LO] = ~row;
                    end
                    issue(OP_MUX_WR, d, 1'b0, '0);
                end
                if ($urandom_range(0, 4) == 0)
                begin
                    issue(OP_MUX_WR, 8'($urandom_range(0, 255)), 1'b0, '0);
                    spare_writes++;
                end
            end
            else
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                    issue(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'b0, '0);
            end
        end

        calm = 1'b0;
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d accesses: %0d control, %0d mux, %0d mailbox read, %0d host write",
                 n_ctrl + n_mux + n_rd + n_wr, n_ctrl, n_mux, n_rd, n_wr);
        $display("Rows emitted %0d, rows past the limit %0d, mailbox bytes read back %0d",
                 rows_shown, rows_dropped, mail_hits);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/dmrc_pkg.sv
rtl/core/dmrc_ifs.sv
rtl/core/dmrc_in_stage.sv
rtl/core/dmrc_core.sv
rtl/core/dmrc_out_stage.sv
rtl/core/dot_matrix_row_capture.sv
bench/dot_matrix_row_capture_test.sv
